// ===== design/lcs_pkg.sv =====
`default_nettype none

package lcs_pkg;

    localparam int MAX_COLS_DEF = 2048;
    localparam int SIDE_W       = 12;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_ADDR_W   = 3;

    localparam logic [SIDE_W-1:0] ROW_WIDTH_RESET = 12'd2048;
    localparam logic [SIDE_W-1:0] SIDE_ONE        = 12'd1;
    localparam logic [SIDE_W-1:0] SIDE_SAT        = 12'hFFF;

    // register index, taken from paddr above the byte offset
    localparam logic [CFG_ADDR_W-3:0] REG_ROW_WIDTH = '0;

    typedef struct packed {
        logic cell_bit;
        logic last_cell;
    } lcs_in_t;

    typedef struct packed {
        logic [SIDE_W-1:0] cell_side;
        logic [SIDE_W-1:0] best_side;
        logic              is_final;
    } lcs_out_t;

endpackage

`default_nettype wire

// ===== design/largest_checkerboard_square.sv =====
// channel  | handshake           | payload
// ---------+---------------------+----------------------------------------
// in       | in_valid / in_ready | in_item   (cell_bit, last_cell)
// out      | out_valid/out_ready | out_item  (cell_side, best_side, is_final)
// cfg      | apb psel/penable    | paddr, pwdata, prdata (row_width)
//
// one item per cycle sustained while out_ready holds; an accepted item passes the compute stage
// register and then the output register; the line store is read at accept and written when the
// item leaves the compute stage, with a bypass when both touch the same column (row_width of one)
// reset clears control and neighbor state; the line store is never cleared
// a stalled output holds its item in the output register; the compute stage
// and the input stay open until both hold an item
`default_nettype none

module largest_checkerboard_square #(
    parameter int MAX_COLS = lcs_pkg::MAX_COLS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire  lcs_pkg::lcs_in_t               in_item,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output lcs_pkg::lcs_out_t                    out_item,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [lcs_pkg::CFG_ADDR_W-1:0]       paddr,
    input  wire  [lcs_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [lcs_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    localparam int SW   = lcs_pkg::SIDE_W;
    localparam int AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CW   = (AW + 1 > SW + 1) ? AW + 1 : SW + 1;
    localparam int WW   = SW + 1;

    // configuration
    logic [SW-1:0] row_width_reg;
    logic          cfg_wr;
    logic          cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[lcs_pkg::CFG_ADDR_W-1:2] == lcs_pkg::REG_ROW_WIDTH);
    assign cfg_wr  = psel && penable && pwrite && cfg_sel;
    assign prdata  = cfg_sel ? lcs_pkg::CFG_DATA_W'(row_width_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= lcs_pkg::ROW_WIDTH_RESET;
        end
        else if (cfg_wr)
        begin
            row_width_reg <= pwdata[SW-1:0];
        end
    end

    // handshake
    logic s1_valid_reg;
    logic s1_go;
    logic in_accept;
    logic out_valid_reg;

    assign s1_go     = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || s1_go;
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // column tracking at accept
    logic [AW-1:0] col_reg;
    logic [AW-1:0] col_next;
    logic          first_row_reg;
    logic          first_row_next;
    logic [CW-1:0] width_raw;
    logic [CW-1:0] width_eff;
    logic [CW-1:0] col_inc;

    always_comb
    begin
        width_raw = CW'(row_width_reg);
        if (width_raw == '0)
        begin
            width_eff = CW'(1);
        end
        else if (width_raw > CW'(MAX_COLS))
        begin
            width_eff = CW'(MAX_COLS);
        end
        else
        begin
            width_eff = width_raw;
        end
        col_inc        = CW'(col_reg) + CW'(1);
        col_next       = col_reg;
        first_row_next = first_row_reg;
        if (in_accept)
        begin
            if (in_item.last_cell)
            begin
                col_next       = '0;
                first_row_next = 1'b1;
            end
            else if (col_inc >= width_eff)
            begin
                col_next       = '0;
                first_row_next = 1'b0;
            end
            else
            begin
                col_next = col_inc[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            first_row_reg <= 1'b1;
        end
        else
        begin
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
        end
    end

    // compute stage payload
    logic          s1_bit_reg;
    logic          s1_last_reg;
    logic          s1_force_reg;
    logic [AW-1:0] s1_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_bit_reg   <= in_item.cell_bit;
            s1_last_reg  <= in_item.last_cell;
            s1_force_reg <= first_row_reg || (col_reg == '0);
            s1_col_reg   <= col_reg;
        end
    end

    // line store: {colour, side} per column
    logic [WW-1:0] line_mem [MAX_COLS];
    logic [WW-1:0] rd_word_reg;
    logic [WW-1:0] wr_word;
    logic          wr_en;
    logic          fwd;

    assign wr_en = s1_valid_reg && s1_go;
    assign fwd   = wr_en && (s1_col_reg == col_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[s1_col_reg] <= wr_word;
        end
        if (in_accept)
        begin
            rd_word_reg <= fwd ? wr_word : line_mem[col_reg];
        end
    end

    // side computation
    logic [SW-1:0] left_side_reg;
    logic          left_colour_reg;
    logic [SW-1:0] diag_side_reg;
    logic          diag_colour_reg;
    logic [SW-1:0] best_reg;
    logic [SW-1:0] up_side;
    logic          up_colour;
    logic [SW-1:0] u_val;
    logic [SW-1:0] l_val;
    logic [SW-1:0] d_val;
    logic [SW-1:0] m_val;
    logic [SW:0]   sum;
    logic [SW-1:0] side;
    logic [SW-1:0] best_new;

    always_comb
    begin
        up_side   = rd_word_reg[SW-1:0];
        up_colour = rd_word_reg[SW];
        u_val     = (up_colour != s1_bit_reg) ? up_side : '0;
        l_val     = (left_colour_reg != s1_bit_reg) ? left_side_reg : '0;
        d_val     = (diag_colour_reg == s1_bit_reg) ? diag_side_reg : '0;
        m_val     = (u_val < l_val) ? u_val : l_val;
        m_val     = (d_val < m_val) ? d_val : m_val;
        sum       = {1'b0, m_val} + (SW+1)'(1);
        if (s1_force_reg)
        begin
            side = lcs_pkg::SIDE_ONE;
        end
        else if (sum[SW])
        begin
            side = lcs_pkg::SIDE_SAT;
        end
        else
        begin
            side = sum[SW-1:0];
        end
        best_new = (side > best_reg) ? side : best_reg;
        wr_word  = {s1_bit_reg, side};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_side_reg   <= '0;
            left_colour_reg <= 1'b0;
            diag_side_reg   <= '0;
            diag_colour_reg <= 1'b0;
            best_reg        <= lcs_pkg::SIDE_ONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s1_go)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (wr_en)
            begin
                left_side_reg   <= side;
                left_colour_reg <= s1_bit_reg;
                diag_side_reg   <= up_side;
                diag_colour_reg <= up_colour;
                best_reg        <= s1_last_reg ? lcs_pkg::SIDE_ONE : best_new;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            out_item.cell_side <= side;
            out_item.best_side <= best_new;
            out_item.is_final  <= s1_last_reg;
        end
    end

endmodule

`default_nettype wire

// ===== design/lcs_checker.sv =====
`default_nettype none

module lcs_checker (
    input wire                     clk,
    input wire                     rst_n,
    input wire                     in_valid,
    input wire                     in_ready,
    input wire                     out_valid,
    input wire                     out_ready,
    input wire lcs_pkg::lcs_out_t  out_item
);

    // a stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output item changed while stalled");

    // input only blocks behind a stalled output
    a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input blocked without output backpressure");

    // running best covers the current cell
    a_best_ge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.best_side >= out_item.cell_side)
        else $error("best side below cell side");

    // sides are never zero
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.cell_side != '0 && out_item.best_side != '0)
        else $error("zero side reported");

endmodule

bind largest_checkerboard_square lcs_checker u_lcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

`default_nettype wire
